FILE: src/iptxt_pkg.sv
// shared types, constants and the bcd adjust step for the integer-to-text block
// no dependencies
package iptxt_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int MW_W       = 7;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int DIG_W      = 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CH_BLANK = 7'h20;

  // register index, taken from paddr[2]
  localparam logic REG_MIN_WIDTH = 1'b0;

  localparam logic [MW_W-1:0]      MAX_WIDTH_V = MW_W'(MAX_WIDTH);
  localparam logic [DIG_W-1:0]     ND_FULL     = DIG_W'(NUM_DIGITS);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST    = BIT_CNT_W'(VALUE_W - 1);

  // converter status seen by the character sequencer
  typedef struct packed {
    logic             done;
    logic             neg;
    logic [DIG_W-1:0] nd;
    logic [DIG_W-1:0] digit;
  } conv_stat_t;

  // add 3 to every bcd digit that is 5 or more, ahead of the shift
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

FILE: src/iptxt_regs.sv
// configuration register file: minimum field width behind an apb-style port
// depends on iptxt_pkg
module iptxt_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iptxt_pkg::ADDR_W-1:0]  paddr,
  input  logic [iptxt_pkg::DATA_W-1:0]  pwdata,
  output logic [iptxt_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [iptxt_pkg::MW_W-1:0]    min_width_o
);
  import iptxt_pkg::*;

  logic [MW_W-1:0] min_width_q, min_width_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_MIN_WIDTH);

  always_comb begin
    min_width_d = min_width_q;
    if (wr_en) begin
      min_width_d = pwdata[MW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q <= '0;
    end else begin
      min_width_q <= min_width_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_WIDTH) begin
      prdata = {{(DATA_W-MW_W){1'b0}}, min_width_q};
    end
  end

  assign min_width_o = min_width_q;

endmodule

FILE: src/iptxt_conv.sv
// bit-serial binary to bcd converter (shift and add 3) with leading-zero alignment
// depends on iptxt_pkg
module iptxt_conv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic signed [iptxt_pkg::VALUE_W-1:0] value_i,
  input  logic                                shift_i,
  output logic                                busy_o,
  output iptxt_pkg::conv_stat_t               stat_o
);
  import iptxt_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE   = 3'b001,
    C_DABBLE = 3'b010,
    C_ALIGN  = 3'b100
  } conv_state_e;

  conv_state_e          state_q, state_d;
  logic [VALUE_W-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [DIG_W-1:0]     nd_q, nd_d;
  logic                 neg_q, neg_d;
  logic                 done;
  logic [VALUE_W-1:0]   raw;

  assign raw     = $unsigned(value_i);
  assign bcd_adj = bcd_adjust(bcd_q);

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    nd_d      = nd_q;
    neg_d     = neg_q;
    done      = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (load_i) begin
          neg_d     = raw[VALUE_W-1];
          bin_d     = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
          bcd_d     = '0;
          bit_cnt_d = '0;
          nd_d      = ND_FULL;
          state_d   = C_DABBLE;
        end else if (shift_i) begin
          bcd_d = {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
        end
      end
      C_DABBLE: begin
        {bcd_d, bin_d} = {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
        bit_cnt_d      = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_LAST) begin
          state_d = C_ALIGN;
        end
      end
      C_ALIGN: begin
        // drop leading zero digits, keep at least one
        if ((bcd_q[BCD_W-1 -: DIG_W] == '0) && (nd_q > 4'd1)) begin
          bcd_d = {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
          nd_d  = nd_q - 1'b1;
        end else begin
          done    = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    nd_q      <= nd_d;
    neg_q     <= neg_d;
  end

  assign busy_o       = (state_q != C_IDLE);
  assign stat_o.done  = done;
  assign stat_o.neg   = neg_q;
  assign stat_o.nd    = nd_q;
  assign stat_o.digit = bcd_q[BCD_W-1 -: DIG_W];

endmodule

FILE: src/iptxt_emit.sv
// character sequencer: blanks, sign, then digits, one character per cycle
// depends on iptxt_pkg
module iptxt_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  iptxt_pkg::conv_stat_t           stat_i,
  input  logic [iptxt_pkg::MW_W-1:0]      min_width_i,
  output logic                            shift_o,
  output logic                            busy_o,
  output logic                            valid_o,
  output logic [iptxt_pkg::CHAR_W-1:0]    char_o,
  output logic                            last_o
);
  import iptxt_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE = 2'b01,
    E_RUN  = 2'b10
  } emit_state_e;

  emit_state_e     state_q, state_d;
  logic [MW_W-1:0] remain_q, remain_d;
  logic [MW_W-1:0] pad_q, pad_d;
  logic            neg_q, neg_d;
  logic [MW_W-1:0] len;
  logic [MW_W-1:0] width;
  logic [MW_W-1:0] total;

  // text length and field size, worked out once per transfer
  assign len   = MW_W'(stat_i.nd) + MW_W'(stat_i.neg);
  assign width = (min_width_i > MAX_WIDTH_V) ? MAX_WIDTH_V : min_width_i;
  assign total = (width > len) ? width : len;

  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    pad_d    = pad_q;
    neg_d    = neg_q;
    valid_o  = 1'b0;
    char_o   = CH_BLANK;
    last_o   = 1'b0;
    shift_o  = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (stat_i.done) begin
          remain_d = total;
          pad_d    = total - len;
          neg_d    = stat_i.neg;
          state_d  = E_RUN;
        end
      end
      E_RUN: begin
        valid_o  = 1'b1;
        remain_d = remain_q - 1'b1;
        if (pad_q != '0) begin
          char_o = CH_BLANK;
          pad_d  = pad_q - 1'b1;
        end else if (neg_q) begin
          char_o = CH_MINUS;
          neg_d  = 1'b0;
        end else begin
          char_o  = CH_ZERO + CHAR_W'(stat_i.digit);
          shift_o = 1'b1;
        end
        if (remain_q == MW_W'(1)) begin
          last_o  = 1'b1;
          state_d = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
    pad_q    <= pad_d;
    neg_q    <= neg_d;
  end

  assign busy_o = (state_q != E_IDLE);

endmodule

FILE: src/integer_to_padded_decimal_text.sv
// top level: signed 32-bit integer to right-aligned decimal ascii text
// depends on iptxt_pkg, iptxt_regs, iptxt_conv, iptxt_emit
//
//  channel   ports                                    transfer when
//  ------    -----------------------------------      ------------------------------
//  input     start, busy, value_i                     start high while busy low
//  result    out_valid_o, character_o, last_o         out_valid_o high (one cycle)
//  config    psel penable pwrite paddr pwdata         psel & penable & pwrite & pready
//
// an item passes through the bit-serial bcd converter, then has its leading zeros stripped
// until nd digits remain (nd = digit count), then is sent one character per cycle
// (max of text length and min_width, capped at 64); busy is high throughout.
// reset clears the min_width register to 0 and returns both sequencers to idle.
// results cannot be held off; each character is shown for exactly one cycle.
module integer_to_padded_decimal_text (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [iptxt_pkg::VALUE_W-1:0] value_i,
  output logic                                 out_valid_o,
  output logic [iptxt_pkg::CHAR_W-1:0]         character_o,
  output logic                                 last_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [iptxt_pkg::ADDR_W-1:0]         paddr,
  input  logic [iptxt_pkg::DATA_W-1:0]         pwdata,
  output logic [iptxt_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import iptxt_pkg::*;

  logic            conv_busy;
  logic            emit_busy;
  logic            shift;
  logic            load;
  logic [MW_W-1:0] min_width;
  conv_stat_t      conv_stat;

  assign busy = conv_busy | emit_busy;
  assign load = start & ~busy;

  iptxt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .min_width_o (min_width)
  );

  iptxt_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .value_i (value_i),
    .shift_i (shift),
    .busy_o  (conv_busy),
    .stat_o  (conv_stat)
  );

  iptxt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (conv_stat),
    .min_width_i (min_width),
    .shift_o     (shift),
    .busy_o      (emit_busy),
    .valid_o     (out_valid_o),
    .char_o      (character_o),
    .last_o      (last_o)
  );

`ifndef NO_ASSERTIONS
  // the converter and the sequencer never run at the same time
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(conv_busy && emit_busy))
    else $error("converter and sequencer both active");

  // the final character of a transfer returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !busy)
    else $error("block still busy after last character");

  // an accepted item starts the converter
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> conv_busy)
    else $error("accepted item did not start conversion");

  // no digit shift is requested while a conversion is in progress
  a_shift_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> !conv_busy)
    else $error("digit shift during conversion");
`endif

endmodule

FILE: dv/tb.sv
// testbench for integer_to_padded_decimal_text: directed and random integers at many field widths
// each character is checked against an in-bench text formatter; depends on iptxt_pkg and the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iptxt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  localparam logic [ADDR_W-1:0] ADDR_MIN_WIDTH = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_UNUSED    = ADDR_W'(4);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic                      clk_i;
  logic                      rst_ni  = 1'b0;
  logic                      start   = 1'b0;
  logic                      busy;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      out_valid_o;
  logic [CHAR_W-1:0]         character_o;
  logic                      last_o;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [ADDR_W-1:0]         paddr   = '0;
  logic [DATA_W-1:0]         pwdata  = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  text_char_t     pending_chars[$];
  logic [MW_W-1:0] field_width = '0;
  bit             idle_on      = 1'b1;
  int             failures     = 0;
  int             chars_checked = 0;
  int             values_sent   = 0;
  int             reg_writes    = 0;
  int             cycle_count   = 0;

  integer_to_padded_decimal_text dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // queue the characters of one value, right-aligned in the current field width
  function automatic void format_decimal(input logic signed [VALUE_W-1:0] v,
                                         input logic [MW_W-1:0] mw);
    logic [VALUE_W-1:0] mag;
    logic [DIG_W-1:0]   digs[NUM_DIGITS];
    logic [CHAR_W-1:0]  text[NUM_DIGITS + 1];
    int                 nd;
    int                 len;
    int                 fw;
    int                 total;
    int                 pad;
    text_char_t         c;
    mag = unsigned'(v);
    if (v[VALUE_W-1]) begin
      mag = 32'd0 - mag;
    end
    nd = 0;
    do begin
      digs[nd] = DIG_W'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0 && nd < NUM_DIGITS);
    len = 0;
    if (v[VALUE_W-1]) begin
      text[len] = CH_MINUS;
      len++;
    end
    while (nd > 0) begin
      nd--;
      text[len] = CH_ZERO + CHAR_W'(digs[nd]);
      len++;
    end
    fw = (int'(mw) > MAX_WIDTH) ? MAX_WIDTH : int'(mw);
    total = (fw > len) ? fw : len;
    pad = total - len;
    for (int k = 0; k < total; k++) begin
      c.ch   = (k < pad) ? CH_BLANK : text[k - pad];
      c.last = (k == total - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] p10;
    int                 k;
    mag = $urandom;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: begin
        // a random digit count, so short texts are as common as long ones
        k = $urandom_range(1, 9);
        p10 = 1;
        repeat (k) p10 = p10 * 10;
        mag = $urandom_range(0, p10 - 1);
      end
      2: begin
        k = $urandom_range(0, 9);
        p10 = 1;
        repeat (k) p10 = p10 * 10;
        mag = $urandom_range(0, 1) ? p10 : p10 - 1;
      end
      3: begin
        mag = 32'h8000_0000 - $urandom_range(0, 20);
        return $urandom_range(0, 1) ? signed'(mag) : signed'(mag - 1);
      end
      default: mag = $urandom_range(0, 99);
    endcase
    return $urandom_range(0, 1) ? signed'(32'd0 - mag) : signed'(mag);
  endfunction

  // each result is on the ports for one cycle and cannot be held off
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o === 1'b1) begin
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("unexpected character %h last %b", character_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (character_o !== want.ch || last_o !== want.last) begin
          note_failure($sformatf("expected char %h last %b, got char %h last %b",
                                 want.ch, want.last, character_o, last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d characters outstanding", pending_chars.size());
      $display("integer_to_padded_decimal_text test failed");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
  endtask

  task automatic check_width_readback();
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, ADDR_MIN_WIDTH, '0, rd);
    if (rd !== DATA_W'(field_width)) begin
      note_failure($sformatf("min_width read back %h, expected %h", rd, field_width));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // only called while the block is idle
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b1, addr, data, rd);
    reg_writes++;
    if (addr[2] == REG_MIN_WIDTH) begin
      field_width = data[MW_W-1:0];
    end
    check_width_readback();
  endtask

  task automatic maybe_pause();
    int n;
    if (!idle_on || $urandom_range(0, 2) != 0) return;
    start   <= 1'b0;
    value_i <= $urandom;
    // sometimes let the block go idle first so the gap also lands there
    if ($urandom_range(0, 3) == 0) begin
      do @(posedge clk_i); while (busy !== 1'b0);
    end
    n = $urandom_range(1, 16);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    format_decimal(v, field_width);
    values_sent++;
    maybe_pause();
  endtask

  // wait until every queued character has come out and the block is idle
  task automatic drain();
    if (start) begin
      start <= 1'b0;
    end
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic test_reset_and_extremes();
    check_width_readback();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(-9);
    send_value(10);
    send_value(32'sh7fff_ffff);
    send_value(32'sh8000_0000);
    send_value(32'sh8000_0001);
    send_value(1000000000);
    drain();
  endtask

  task automatic test_padding();
    write_reg(ADDR_MIN_WIDTH, 5);
    send_value(0);
    send_value(-1234);
    send_value(12345);
    send_value(-12345);
    drain();
    write_reg(ADDR_MIN_WIDTH, 11);
    send_value(32'sh8000_0000);
    drain();
    write_reg(ADDR_MIN_WIDTH, 12);
    send_value(32'sh8000_0000);
    drain();
    write_reg(ADDR_MIN_WIDTH, MAX_WIDTH);
    send_value(7);
    drain();
  endtask

  task automatic test_register_decode();
    write_reg(ADDR_MIN_WIDTH, 2);
    write_reg(ADDR_UNUSED, 40);
    send_value(5);
    drain();
    // upper bits of the written word are dropped
    write_reg(ADDR_MIN_WIDTH, 32'hffff_ff85);
    send_value(42);
    drain();
    // widths past the cap saturate
    write_reg(ADDR_MIN_WIDTH, 127);
    send_value(-1);
    drain();
    write_reg(ADDR_MIN_WIDTH, 65);
    send_value(123);
    drain();
    write_reg(ADDR_MIN_WIDTH, 0);
    send_value(-5);
    drain();
  endtask

  task automatic test_random();
    logic [DATA_W-1:0] w;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: w = $urandom_range(0, 12);
        5, 6, 7:       w = $urandom_range(13, 20);
        8:             w = MAX_WIDTH;
        default:       w = $urandom_range(65, 127);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        w = w | ($urandom << MW_W);
      end
      write_reg(ADDR_MIN_WIDTH, w);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(ADDR_UNUSED, $urandom);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 16; i++) begin
        send_value(random_value());
      end
      drain();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_reg(ADDR_MIN_WIDTH, $urandom_range(0, 16));
    for (int i = 0; i < 24; i++) begin
      send_value(random_value());
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_extremes();
    test_padding();
    test_register_decode();
    test_random();
    test_back_to_back();
    failures += pending_chars.size();
    $display("converted %0d values into %0d checked characters", values_sent, chars_checked);
    $display("%0d register writes, field widths from 0 up to the saturation range", reg_writes);
    if (failures == 0) begin
      $display("integer_to_padded_decimal_text test passed");
    end else begin
      $display("%0d failures", failures);
      $display("integer_to_padded_decimal_text test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/iptxt_pkg.sv
src/iptxt_regs.sv
src/iptxt_conv.sv
src/iptxt_emit.sv
src/integer_to_padded_decimal_text.sv
dv/tb.sv
